[hdl/ovp_pkg.sv]
`timescale 1ns / 1ps

package ovp_pkg;

    localparam int IN_WIDTH      = 32;
    localparam int OUT_FRAC_BITS = 30;
    localparam int OUT_W         = 32;

    localparam int LIMB_W  = 32;
    localparam int LIMB_N  = (3 * IN_WIDTH + LIMB_W - 1) / LIMB_W;
    localparam int MUL_W   = LIMB_W * LIMB_N;
    localparam int MUL_LAT = 3;

    localparam int SQ_A_W = 2 * IN_WIDTH;
    localparam int N_W    = 2 * IN_WIDTH + 2;
    localparam int W_W    = MUL_W + 2;
    localparam int WSQ_W  = 2 * MUL_W;
    localparam int SQ_W   = WSQ_W + 2;

    localparam int ROOT_N   = OUT_FRAC_BITS + 2;
    localparam int ROOT_SHL = 2 * OUT_FRAC_BITS + 2;
    localparam int RW       = SQ_W + ROOT_SHL + 2;
    localparam int LANE_LAT = ROOT_N + 1;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] in_along_x;
        logic signed [IN_WIDTH-1:0] in_along_y;
        logic signed [IN_WIDTH-1:0] in_along_z;
        logic signed [IN_WIDTH-1:0] in_across_x;
        logic signed [IN_WIDTH-1:0] in_across_y;
        logic signed [IN_WIDTH-1:0] in_across_z;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_along_x;
        logic signed [OUT_W-1:0] out_along_y;
        logic signed [OUT_W-1:0] out_along_z;
        logic signed [OUT_W-1:0] out_across_x;
        logic signed [OUT_W-1:0] out_across_y;
        logic signed [OUT_W-1:0] out_across_z;
        logic                    degenerate;
    } out_t;

    typedef struct packed {
        logic                     valid;
        logic [2:0]               a_neg;
        logic [2:0][IN_WIDTH-1:0] a_mag;
        logic [2:0][IN_WIDTH-1:0] c_mag;
        logic [5:0]               x_neg;
    } p1_t;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             a_neg;
        logic [2:0][IN_WIDTH-1:0] a_mag;
        logic [2:0][SQ_A_W-1:0] a_sq;
        logic [N_W-1:0]         sa;
        logic [2:0][N_W-1:0]    n;
    } c_t;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic [2:0]             a_neg;
        logic [2:0][SQ_A_W-1:0] a_sq;
        logic [N_W-1:0]         sa;
        logic [5:0]             w_neg;
    } p2_t;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic [2:0]             a_neg;
        logic [2:0][SQ_A_W-1:0] a_sq;
        logic [N_W-1:0]         sa;
        logic [2:0][W_W-1:0]    w;
    } d_t;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic [2:0]             a_neg;
        logic [2:0][SQ_A_W-1:0] a_sq;
        logic [N_W-1:0]         sa;
        logic [2:0]             w_neg;
    } p3_t;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic [2:0]             a_neg;
        logic [2:0][SQ_A_W-1:0] a_sq;
        logic [N_W-1:0]         sa;
        logic [2:0]             w_neg;
        logic [2:0][WSQ_W-1:0]  wsq;
        logic [SQ_W-1:0]        sw;
    } e_t;

    typedef struct packed {
        logic valid;
        logic degen;
    } meta_t;

endpackage

[hdl/ovp_mul.sv]
`timescale 1ns / 1ps

module ovp_mul (
    input  logic                          clk,
    input  logic [ovp_pkg::MUL_W-1:0]     a,
    input  logic [ovp_pkg::MUL_W-1:0]     b,
    output logic [2*ovp_pkg::MUL_W-1:0]   p
);

    localparam int LW = ovp_pkg::LIMB_W;
    localparam int LN = ovp_pkg::LIMB_N;
    localparam int PW = 2 * LW;
    localparam int RWID = PW + LW * (LN - 1);
    localparam int OW = 2 * ovp_pkg::MUL_W;

    logic [PW-1:0]   pp_reg  [0:LN-1][0:LN-1];
    logic [RWID-1:0] row_reg [0:LN-1];
    logic [RWID-1:0] row_next [0:LN-1];
    logic [OW-1:0]   p_reg;
    logic [OW-1:0]   p_next;

    always_comb
    begin
        for (int i = 0; i < LN; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < LN; j++)
            begin
                row_next[i] = row_next[i] + (RWID'(pp_reg[i][j]) << (LW * j));
            end
        end
        p_next = '0;
        for (int i = 0; i < LN; i++)
        begin
            p_next = p_next + (OW'(row_reg[i]) << (LW * i));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LN; i++)
        begin
            for (int j = 0; j < LN; j++)
            begin
                pp_reg[i][j] <= PW'(a[i*LW +: LW]) * PW'(b[j*LW +: LW]);
            end
            row_reg[i] <= row_next[i];
        end
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[hdl/ovp_lane.sv]
`timescale 1ns / 1ps

module ovp_lane (
    input  logic                        clk,
    input  logic [ovp_pkg::SQ_W-1:0]    v2,
    input  logic [ovp_pkg::SQ_W-1:0]    s,
    input  logic                        neg,
    output logic [ovp_pkg::OUT_W-1:0]   comp
);

    localparam int NS  = ovp_pkg::ROOT_N;
    localparam int RWD = ovp_pkg::RW;
    localparam int SW  = ovp_pkg::SQ_W;
    localparam int OW  = ovp_pkg::OUT_W;

    logic [RWD-1:0] r_reg   [0:NS-1];
    logic [RWD-1:0] p_reg   [0:NS-1];
    logic [SW-1:0]  s_reg   [0:NS-1];
    logic [NS-1:0]  y_reg   [0:NS-1];
    logic           neg_reg [0:NS-1];

    logic [RWD-1:0] r_cur   [0:NS-1];
    logic [RWD-1:0] p_cur   [0:NS-1];
    logic [SW-1:0]  s_cur   [0:NS-1];
    logic [NS-1:0]  y_cur   [0:NS-1];
    logic           neg_cur [0:NS-1];

    logic [NS:0]    lo;
    logic [OW-1:0]  mag;
    logic [OW-1:0]  comp_reg;
    logic [OW-1:0]  comp_next;

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_root
            localparam int K = NS - 1 - j;
            logic [RWD-1:0] sub;
            logic           take;

            if (j == 0)
            begin : g_first
                assign r_cur[j]   = RWD'(v2) << ovp_pkg::ROOT_SHL;
                assign p_cur[j]   = '0;
                assign s_cur[j]   = s;
                assign y_cur[j]   = '0;
                assign neg_cur[j] = neg;
            end
            else
            begin : g_rest
                assign r_cur[j]   = r_reg[j-1];
                assign p_cur[j]   = p_reg[j-1];
                assign s_cur[j]   = s_reg[j-1];
                assign y_cur[j]   = y_reg[j-1];
                assign neg_cur[j] = neg_reg[j-1];
            end

            // trial of bit k: 2^(k+1)*y*s + 2^(2k)*s against the residual
            assign sub  = (p_cur[j] << (K + 1)) + (RWD'(s_cur[j]) << (2 * K));
            assign take = (sub <= r_cur[j]);

            always_ff @(posedge clk)
            begin
                r_reg[j]   <= take ? (r_cur[j] - sub) : r_cur[j];
                p_reg[j]   <= take ? (p_cur[j] + (RWD'(s_cur[j]) << K)) : p_cur[j];
                s_reg[j]   <= s_cur[j];
                y_reg[j]   <= y_cur[j] | (NS'(take) << K);
                neg_reg[j] <= neg_cur[j];
            end
        end
    endgenerate

    // round half away from zero from the extra fraction bit
    assign lo        = ({1'b0, y_reg[NS-1]} + (NS+1)'(1)) >> 1;
    assign mag       = OW'(lo);
    assign comp_next = neg_reg[NS-1] ? (OW'(0) - mag) : mag;

    always_ff @(posedge clk)
    begin
        comp_reg <= comp_next;
    end

    assign comp = comp_reg;

endmodule

[hdl/orthonormalize_vector_pair_top.sv]
`timescale 1ns / 1ps

// orthonormalise a pair of 3-vectors (along, across) into unit vectors in q1.30
// input: operands carries the six signed components; a beat is taken at each
//   rising edge with start high and busy low. busy is always low, so a new
//   pair may be started in every cycle
// output: result carries both unit vectors and the degenerate flag; done is
//   registered, stays high for exactly one cycle per beat and the result is
//   valid while done is high
// throughput: one pair per cycle, set by a fully pipelined datapath: three
//   three-stage limb multiplier banks (cross product, second cross product,
//   squares) and one 32-stage restoring root/divide lane per output component
// degenerate: a zero vector or parallel vectors give degenerate high and all
//   six components zero
// reset: rst_n clears the valid bits in flight; items in the pipe are dropped
// the receiver cannot stall: every result is shown once and must be taken
module orthonormalize_vector_pair_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ovp_pkg::in_t   operands,
    output logic           done,
    output ovp_pkg::out_t  result
);

    localparam int IW   = ovp_pkg::IN_WIDTH;
    localparam int MW   = ovp_pkg::MUL_W;
    localparam int ML   = ovp_pkg::MUL_LAT;
    localparam int NW   = ovp_pkg::N_W;
    localparam int WW   = ovp_pkg::W_W;
    localparam int QW   = ovp_pkg::SQ_W;
    localparam int AQW  = ovp_pkg::SQ_A_W;
    localparam int WQW  = ovp_pkg::WSQ_W;
    localparam int LL   = ovp_pkg::LANE_LAT;
    localparam int OW   = ovp_pkg::OUT_W;

    logic [IW-1:0] in_val [0:5];
    logic [5:0]    in_neg;
    logic [IW-1:0] in_mag [0:5];

    ovp_pkg::p1_t  p1_reg [0:ML];
    ovp_pkg::p1_t  p1_next;
    ovp_pkg::c_t   c_reg;
    ovp_pkg::c_t   c_next;
    ovp_pkg::p2_t  p2_reg [0:ML-1];
    ovp_pkg::p2_t  p2_next;
    ovp_pkg::d_t   d_reg;
    ovp_pkg::d_t   d_next;
    ovp_pkg::p3_t  p3_reg [0:ML-1];
    ovp_pkg::p3_t  p3_next;
    ovp_pkg::e_t   e_reg;
    ovp_pkg::e_t   e_next;
    ovp_pkg::meta_t m_reg [0:LL-1];
    ovp_pkg::meta_t m_next;
    ovp_pkg::out_t res_reg;
    ovp_pkg::out_t res_next;
    logic          done_reg;

    logic [MW-1:0]   m1_a [0:8];
    logic [MW-1:0]   m1_b [0:8];
    logic [2*MW-1:0] m1_p [0:8];
    logic [MW-1:0]   m2_a [0:5];
    logic [MW-1:0]   m2_b [0:5];
    logic [2*MW-1:0] m2_p [0:5];
    logic [MW-1:0]   m3_a [0:2];
    logic [2*MW-1:0] m3_p [0:2];

    logic [NW-1:0]   sgn1 [0:5];
    logic [NW-1:0]   n_mag [0:2];
    logic [WW-1:0]   sgn2 [0:5];
    logic [WW-1:0]   w_mag [0:2];

    logic [QW-1:0]   l_v2  [0:5];
    logic [QW-1:0]   l_s   [0:5];
    logic            l_neg [0:5];
    logic [OW-1:0]   l_out [0:5];

    assign busy = 1'b0;

    // input beat: sign and magnitude
    always_comb
    begin
        in_val[0] = operands.in_along_x;
        in_val[1] = operands.in_along_y;
        in_val[2] = operands.in_along_z;
        in_val[3] = operands.in_across_x;
        in_val[4] = operands.in_across_y;
        in_val[5] = operands.in_across_z;
        for (int k = 0; k < 6; k++)
        begin
            in_neg[k] = in_val[k][IW-1];
            in_mag[k] = in_neg[k] ? (IW'(0) - in_val[k]) : in_val[k];
        end
        p1_next.valid = start & ~busy;
        for (int i = 0; i < 3; i++)
        begin
            p1_next.a_neg[i] = in_neg[i];
            p1_next.a_mag[i] = in_mag[i];
            p1_next.c_mag[i] = in_mag[3+i];
        end
        // c x a product signs
        p1_next.x_neg[0] = in_neg[4] ^ in_neg[2];
        p1_next.x_neg[1] = in_neg[5] ^ in_neg[1];
        p1_next.x_neg[2] = in_neg[5] ^ in_neg[0];
        p1_next.x_neg[3] = in_neg[3] ^ in_neg[2];
        p1_next.x_neg[4] = in_neg[3] ^ in_neg[1];
        p1_next.x_neg[5] = in_neg[4] ^ in_neg[0];
    end

    // first bank: c x a terms and squares of a
    always_comb
    begin
        m1_a[0] = MW'(p1_reg[0].c_mag[1]);  m1_b[0] = MW'(p1_reg[0].a_mag[2]);
        m1_a[1] = MW'(p1_reg[0].c_mag[2]);  m1_b[1] = MW'(p1_reg[0].a_mag[1]);
        m1_a[2] = MW'(p1_reg[0].c_mag[2]);  m1_b[2] = MW'(p1_reg[0].a_mag[0]);
        m1_a[3] = MW'(p1_reg[0].c_mag[0]);  m1_b[3] = MW'(p1_reg[0].a_mag[2]);
        m1_a[4] = MW'(p1_reg[0].c_mag[0]);  m1_b[4] = MW'(p1_reg[0].a_mag[1]);
        m1_a[5] = MW'(p1_reg[0].c_mag[1]);  m1_b[5] = MW'(p1_reg[0].a_mag[0]);
        for (int i = 0; i < 3; i++)
        begin
            m1_a[6+i] = MW'(p1_reg[0].a_mag[i]);
            m1_b[6+i] = MW'(p1_reg[0].a_mag[i]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 9; g++)
        begin : g_mul1
            ovp_mul u_mul (.clk(clk), .a(m1_a[g]), .b(m1_b[g]), .p(m1_p[g]));
        end
        for (g = 0; g < 6; g++)
        begin : g_mul2
            ovp_mul u_mul (.clk(clk), .a(m2_a[g]), .b(m2_b[g]), .p(m2_p[g]));
        end
        for (g = 0; g < 3; g++)
        begin : g_mul3
            ovp_mul u_mul (.clk(clk), .a(m3_a[g]), .b(m3_a[g]), .p(m3_p[g]));
        end
    endgenerate

    // n = c x a, |a|^2
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            sgn1[k] = p1_reg[ML].x_neg[k] ? (NW'(0) - NW'(m1_p[k][AQW-1:0]))
                                          : NW'(m1_p[k][AQW-1:0]);
        end
        c_next.valid = p1_reg[ML].valid;
        c_next.a_neg = p1_reg[ML].a_neg;
        c_next.a_mag = p1_reg[ML].a_mag;
        for (int i = 0; i < 3; i++)
        begin
            c_next.n[i]    = sgn1[2*i] - sgn1[2*i+1];
            c_next.a_sq[i] = m1_p[6+i][AQW-1:0];
        end
        c_next.sa = NW'(c_next.a_sq[0]) + NW'(c_next.a_sq[1]) + NW'(c_next.a_sq[2]);
    end

    // second bank: w = a x n
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_mag[i] = c_reg.n[i][NW-1] ? (NW'(0) - c_reg.n[i]) : c_reg.n[i];
        end
        m2_a[0] = MW'(c_reg.a_mag[1]);  m2_b[0] = MW'(n_mag[2]);
        m2_a[1] = MW'(c_reg.a_mag[2]);  m2_b[1] = MW'(n_mag[1]);
        m2_a[2] = MW'(c_reg.a_mag[2]);  m2_b[2] = MW'(n_mag[0]);
        m2_a[3] = MW'(c_reg.a_mag[0]);  m2_b[3] = MW'(n_mag[2]);
        m2_a[4] = MW'(c_reg.a_mag[0]);  m2_b[4] = MW'(n_mag[1]);
        m2_a[5] = MW'(c_reg.a_mag[1]);  m2_b[5] = MW'(n_mag[0]);
        p2_next.valid = c_reg.valid;
        p2_next.degen = (c_reg.n[0] == '0) && (c_reg.n[1] == '0) && (c_reg.n[2] == '0);
        p2_next.a_neg = c_reg.a_neg;
        p2_next.a_sq  = c_reg.a_sq;
        p2_next.sa    = c_reg.sa;
        p2_next.w_neg[0] = c_reg.a_neg[1] ^ c_reg.n[2][NW-1];
        p2_next.w_neg[1] = c_reg.a_neg[2] ^ c_reg.n[1][NW-1];
        p2_next.w_neg[2] = c_reg.a_neg[2] ^ c_reg.n[0][NW-1];
        p2_next.w_neg[3] = c_reg.a_neg[0] ^ c_reg.n[2][NW-1];
        p2_next.w_neg[4] = c_reg.a_neg[0] ^ c_reg.n[1][NW-1];
        p2_next.w_neg[5] = c_reg.a_neg[1] ^ c_reg.n[0][NW-1];
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            sgn2[k] = p2_reg[ML-1].w_neg[k] ? (WW'(0) - WW'(m2_p[k][MW-1:0]))
                                            : WW'(m2_p[k][MW-1:0]);
        end
        d_next.valid = p2_reg[ML-1].valid;
        d_next.degen = p2_reg[ML-1].degen;
        d_next.a_neg = p2_reg[ML-1].a_neg;
        d_next.a_sq  = p2_reg[ML-1].a_sq;
        d_next.sa    = p2_reg[ML-1].sa;
        for (int i = 0; i < 3; i++)
        begin
            d_next.w[i] = sgn2[2*i] - sgn2[2*i+1];
        end
    end

    // third bank: squares of w
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w_mag[i]      = d_reg.w[i][WW-1] ? (WW'(0) - d_reg.w[i]) : d_reg.w[i];
            m3_a[i]       = w_mag[i][MW-1:0];
            p3_next.w_neg[i] = d_reg.w[i][WW-1];
        end
        p3_next.valid = d_reg.valid;
        p3_next.degen = d_reg.degen;
        p3_next.a_neg = d_reg.a_neg;
        p3_next.a_sq  = d_reg.a_sq;
        p3_next.sa    = d_reg.sa;
    end

    always_comb
    begin
        e_next.valid = p3_reg[ML-1].valid;
        e_next.degen = p3_reg[ML-1].degen;
        e_next.a_neg = p3_reg[ML-1].a_neg;
        e_next.a_sq  = p3_reg[ML-1].a_sq;
        e_next.sa    = p3_reg[ML-1].sa;
        e_next.w_neg = p3_reg[ML-1].w_neg;
        for (int i = 0; i < 3; i++)
        begin
            e_next.wsq[i] = m3_p[i][WQW-1:0];
        end
        e_next.sw = QW'(m3_p[0]) + QW'(m3_p[1]) + QW'(m3_p[2]);
    end

    // root lanes: along then across
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            l_v2[i]    = QW'(e_reg.a_sq[i]);
            l_s[i]     = QW'(e_reg.sa);
            l_neg[i]   = e_reg.a_neg[i];
            l_v2[3+i]  = QW'(e_reg.wsq[i]);
            l_s[3+i]   = e_reg.sw;
            l_neg[3+i] = e_reg.w_neg[i];
        end
        m_next.valid = e_reg.valid;
        m_next.degen = e_reg.degen;
    end

    generate
        for (g = 0; g < 6; g++)
        begin : g_lane
            ovp_lane u_lane (
                .clk  (clk),
                .v2   (l_v2[g]),
                .s    (l_s[g]),
                .neg  (l_neg[g]),
                .comp (l_out[g])
            );
        end
    endgenerate

    always_comb
    begin
        res_next.degenerate   = m_reg[LL-1].degen;
        res_next.out_along_x  = m_reg[LL-1].degen ? '0 : l_out[0];
        res_next.out_along_y  = m_reg[LL-1].degen ? '0 : l_out[1];
        res_next.out_along_z  = m_reg[LL-1].degen ? '0 : l_out[2];
        res_next.out_across_x = m_reg[LL-1].degen ? '0 : l_out[3];
        res_next.out_across_y = m_reg[LL-1].degen ? '0 : l_out[4];
        res_next.out_across_z = m_reg[LL-1].degen ? '0 : l_out[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ML; k++)
            begin
                p1_reg[k] <= '0;
            end
            for (int k = 0; k < ML; k++)
            begin
                p2_reg[k] <= '0;
                p3_reg[k] <= '0;
            end
            for (int k = 0; k < LL; k++)
            begin
                m_reg[k] <= '0;
            end
            c_reg    <= '0;
            d_reg    <= '0;
            e_reg    <= '0;
            res_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_reg[0] <= p1_next;
            for (int k = 1; k <= ML; k++)
            begin
                p1_reg[k] <= p1_reg[k-1];
            end
            c_reg     <= c_next;
            p2_reg[0] <= p2_next;
            p3_reg[0] <= p3_next;
            for (int k = 1; k < ML; k++)
            begin
                p2_reg[k] <= p2_reg[k-1];
                p3_reg[k] <= p3_reg[k-1];
            end
            d_reg    <= d_next;
            e_reg    <= e_next;
            m_reg[0] <= m_next;
            for (int k = 1; k < LL; k++)
            begin
                m_reg[k] <= m_reg[k-1];
            end
            res_reg  <= res_next;
            done_reg <= m_reg[LL-1].valid;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    typedef logic [319:0] wide_t;
    typedef logic signed [127:0] lane_t;

    localparam int LATENCY  = 47;
    localparam int WD_LIMIT = 5000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    ovp_pkg::in_t   operands = '0;
    logic  done;
    ovp_pkg::out_t  result;

    ovp_pkg::out_t  frames_due[$];
    int    mismatches = 0;
    int    pairs_sent = 0;
    int    frames_seen = 0;
    int    degen_seen = 0;
    int    idle_pct = 0;
    int    quiet_cycles = 0;

    orthonormalize_vector_pair_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always #1 clk = ~clk;

    // one component of v / |v| scaled by 2^30, rounded half away from zero
    function automatic logic [31:0] q30_component(wide_t mag, wide_t sumsq, bit neg);
        wide_t lhs;
        wide_t k;
        wide_t rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lhs = (mag * mag) << (2 * ovp_pkg::OUT_FRAC_BITS + 2);
        lo = 0;
        hi = 64'd1 << ovp_pkg::OUT_FRAC_BITS;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            k = 2 * mid - 1;
            rhs = k * k * sumsq;
            if (lhs >= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return neg ? 32'(0 - lo) : 32'(lo);
    endfunction

    function automatic void unit_of(input lane_t v[3], output logic [31:0] u[3]);
        wide_t m[3];
        wide_t s;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = wide_t'(v[i] < 0 ? -v[i] : v[i]);
            s = s + m[i] * m[i];
        end
        for (int i = 0; i < 3; i++)
            u[i] = q30_component(m[i], s, v[i] < 0);
    endfunction

    function automatic ovp_pkg::out_t unit_frame(ovp_pkg::in_t x);
        lane_t a[3];
        lane_t c[3];
        lane_t n[3];
        lane_t w[3];
        logic [31:0] ua[3];
        logic [31:0] uw[3];
        ovp_pkg::out_t r;
        a[0] = x.in_along_x;  a[1] = x.in_along_y;  a[2] = x.in_along_z;
        c[0] = x.in_across_x; c[1] = x.in_across_y; c[2] = x.in_across_z;
        n[0] = c[1] * a[2] - c[2] * a[1];
        n[1] = c[2] * a[0] - c[0] * a[2];
        n[2] = c[0] * a[1] - c[1] * a[0];
        r = '0;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        w[0] = a[1] * n[2] - a[2] * n[1];
        w[1] = a[2] * n[0] - a[0] * n[2];
        w[2] = a[0] * n[1] - a[1] * n[0];
        unit_of(a, ua);
        unit_of(w, uw);
        r.out_along_x  = ua[0];
        r.out_along_y  = ua[1];
        r.out_along_z  = ua[2];
        r.out_across_x = uw[0];
        r.out_across_y = uw[1];
        r.out_across_z = uw[2];
        return r;
    endfunction

    function automatic ovp_pkg::in_t pair_of(int ax, int ay, int az, int cx, int cy, int cz);
        ovp_pkg::in_t p;
        p.in_along_x  = ax;
        p.in_along_y  = ay;
        p.in_along_z  = az;
        p.in_across_x = cx;
        p.in_across_y = cy;
        p.in_across_z = cz;
        return p;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int small_val(int lim);
        return $urandom_range(0, 2 * lim) - lim;
    endfunction

    function automatic ovp_pkg::in_t random_pair();
        int a[3];
        int c[3];
        int k;
        int lim;
        lim = 1 << $urandom_range(1, 28);
        case ($urandom_range(0, 9))
            5:
            begin
                foreach (a[i]) a[i] = small_val(100);
                foreach (c[i]) c[i] = small_val(100);
            end
            6:
            begin
                k = small_val(4);
                foreach (a[i]) a[i] = small_val(lim);
                foreach (c[i]) c[i] = a[i] * k;
            end
            7:
            begin
                foreach (a[i]) a[i] = $urandom;
                foreach (c[i]) c[i] = $urandom;
                if ($urandom_range(0, 1))
                    a = '{0, 0, 0};
                else
                    c = '{0, 0, 0};
            end
            8:
            begin
                foreach (a[i]) a[i] = pick_extreme();
                foreach (c[i]) c[i] = pick_extreme();
            end
            9:
            begin
                k = small_val(4);
                foreach (a[i]) a[i] = small_val(lim);
                foreach (c[i]) c[i] = a[i] * k + small_val(2);
            end
            default:
            begin
                foreach (a[i]) a[i] = $urandom;
                foreach (c[i]) c[i] = $urandom;
            end
        endcase
        return pair_of(a[0], a[1], a[2], c[0], c[1], c[2]);
    endfunction

    // expectation is taken on the edge that accepts the beat
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            frames_due.push_back(unit_frame(operands));
            pairs_sent++;
        end
    end

    always @(posedge clk)
    begin
        ovp_pkg::out_t want;
        if (rst_n && done)
        begin
            frames_seen++;
            if (result.degenerate)
                degen_seen++;
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = frames_due.pop_front();
                if (result.out_along_x !== want.out_along_x
                    || result.out_along_y !== want.out_along_y
                    || result.out_along_z !== want.out_along_z
                    || result.out_across_x !== want.out_across_x
                    || result.out_across_y !== want.out_across_y
                    || result.out_across_z !== want.out_across_z
                    || result.degenerate !== want.degenerate)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch along exp %0d %0d %0d got %0d %0d %0d",
                                 want.out_along_x, want.out_along_y, want.out_along_z,
                                 result.out_along_x, result.out_along_y,
                                 result.out_along_z);
                        $display("  across exp %0d %0d %0d got %0d %0d %0d degen %b/%b",
                                 want.out_across_x, want.out_across_y, want.out_across_z,
                                 result.out_across_x, result.out_across_y,
                                 result.out_across_z, want.degenerate, result.degenerate);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("watchdog: no progress");
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_pair(ovp_pkg::in_t p);
        int gap;
        start <= 1'b1;
        operands <= p;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(1, 100) <= idle_pct)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            operands <= ovp_pkg::in_t'({$urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic test_directed();
        int mn;
        int mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;
        idle_pct = 0;
        send_pair(pair_of(1, 0, 0, 0, 1, 0));
        send_pair(pair_of(0, 0, 1, 1, 0, 0));
        send_pair(pair_of(mx, mx, mx, mn, mn, mx));
        send_pair(pair_of(mn, mn, mn, mx, 0, 0));
        send_pair(pair_of(mn, 0, 0, 0, mn, 0));
        send_pair(pair_of(mx, 0, 0, 0, 0, mn));
        send_pair(pair_of(mx, mn, 1, -1, mx, mn));
        send_pair(pair_of(0, 0, 0, 3, 4, 5));
        send_pair(pair_of(3, 4, 5, 0, 0, 0));
        send_pair(pair_of(0, 0, 0, 0, 0, 0));
        send_pair(pair_of(1, 2, 3, 2, 4, 6));
        send_pair(pair_of(1, 2, 3, -3, -6, -9));
        send_pair(pair_of(mn, mn, mn, mn, mn, mn));
        send_pair(pair_of(mx, mx, mx, -mx, -mx, -mx));
        send_pair(pair_of(1, 1, 0, 1, 0, 0));
        send_pair(pair_of(1, 1, 1, 1, 2, 3));
        send_pair(pair_of(-1, -1, -1, 1, 0, 0));
        send_pair(pair_of(3, 4, 0, 1, 1, 1));
        send_pair(pair_of(mx, 1, 0, mx, 0, 0));
        send_pair(pair_of(1, 2, 3, 2, 4, 7));
        drain();
    endtask

    task automatic test_random_phase(int pct, int count);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 270);
        test_random_phase(55, 270);
        test_random_phase(15, 270);
        $display("covered %0d pairs incl. extremes, zero and parallel vectors", pairs_sent);
        $display("%0d results checked, %0d degenerate, %0d mismatches",
                 frames_seen, degen_seen, mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/ovp_pkg.sv
hdl/ovp_mul.sv
hdl/ovp_lane.sv
hdl/orthonormalize_vector_pair_top.sv
tb/sv/testbench.sv
